[rtl/isort_pkg.sv]
// Shared types and constants for the insertion sorter.
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

    localparam int KEY_W        = 32;
    localparam int CAPACITY_DEF = 32;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic insert;
        logic pop;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic last_entry;
    } t_dp_status;

endpackage

`default_nettype wire

[rtl/isort_ctrl.sv]
// Controller state machine: accepts keys, then sequences the sorted drain.
`timescale 1ns / 1ps
`default_nettype none

module isort_ctrl
    import isort_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    input  wire logic       i_list_end,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.insert = 1'b0;
        o_cmd.pop    = 1'b0;
        busy         = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_cmd.insert = 1'b1;
                    if (i_list_end) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                busy      = 1'b1;
                o_cmd.pop = 1'b1;
                if (i_status.last_entry) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/isort_dp.sv]
// Datapath: compare-and-shift key array, entry count, drop flag, output registers.
`timescale 1ns / 1ps
`default_nettype none

module isort_dp
    import isort_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic signed [KEY_W-1:0] i_key_in,
    output t_dp_status             o_status,
    output logic                   o_strobe,
    output logic signed [KEY_W-1:0] o_key_out,
    output logic                   o_run_end,
    output logic                   o_overflowed
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [KEY_W-1:0] r_keys [CAPACITY];
    logic signed [KEY_W-1:0] n_keys [CAPACITY];
    logic [CAPACITY-1:0]     gt;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_dropped;
    logic                    n_dropped;
    logic                    full;
    logic                    do_insert;
    logic                    r_strobe;
    logic signed [KEY_W-1:0] r_key_out;
    logic                    r_run_end;
    logic                    r_overflowed;

    assign full      = (r_count == CNT_W'(CAPACITY));
    assign do_insert = i_cmd.insert && !full;
    assign o_status.last_entry = (r_count == CNT_W'(1));

    // Empty slots count as greater, so the new key lands just above the last smaller-or-equal one
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            assign gt[gi] = (CNT_W'(gi) >= r_count) || (r_keys[gi] > i_key_in);

            always_comb begin
                n_keys[gi] = r_keys[gi];
                if (do_insert && gt[gi]) begin
                    if (gi == 0) begin
                        n_keys[gi] = i_key_in;
                    end else if (gt[(gi == 0) ? 0 : gi - 1]) begin
                        n_keys[gi] = r_keys[(gi == 0) ? 0 : gi - 1];
                    end else begin
                        n_keys[gi] = i_key_in;
                    end
                end else if (i_cmd.pop && (gi < CAPACITY - 1)) begin
                    // Advance the array down one slot per drained key
                    n_keys[gi] = r_keys[(gi < CAPACITY - 1) ? gi + 1 : gi];
                end
            end

            always_ff @(posedge i_clk) begin
                r_keys[gi] <= n_keys[gi];
            end
        end
    endgenerate

    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        if (i_cmd.insert) begin
            if (full) begin
                n_dropped = 1'b1;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
            if (o_status.last_entry) begin
                n_dropped = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_strobe  <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_strobe  <= i_cmd.pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_key_out    <= r_keys[0];
            r_run_end    <= o_status.last_entry;
            r_overflowed <= r_dropped;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_key_out    = r_key_out;
    assign o_run_end    = r_run_end;
    assign o_overflowed = r_overflowed;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> (r_count != '0))
        else $error("drain from empty store");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.pop && i_cmd.insert))
        else $error("insert and drain in one cycle");

    a_strobe_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |=> o_strobe)
        else $error("result strobe missing after drain");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop && o_status.last_entry) |=> (r_count == '0 && !r_dropped))
        else $error("store not emptied after last result");

endmodule

`default_nettype wire

[rtl/insertion_sorter.sv]
// Top level of the streaming insertion sorter.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------
//  input    | start, busy        | i_key_in[31:0] signed, i_list_end
//  result   | o_strobe (1 cycle) | o_key_out[31:0] signed, o_run_end,
//           |                    | o_overflowed
//
// A key is taken at any edge with start high and busy low, one key per cycle.
// The key with i_list_end high is inserted (dropped if full), then busy stays high
// while the stored keys drain from the bottom of the shift array, one per cycle.
// Each result shows on the outputs in the cycle after its drain cycle, for one cycle.
// Reset (synchronous, i_rst_n low) empties the store and clears the drop flag.
// The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sorter
    import isort_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic signed [KEY_W-1:0] i_key_in,
    input  wire logic              i_list_end,
    output logic                   o_strobe,
    output logic signed [KEY_W-1:0] o_key_out,
    output logic                   o_run_end,
    output logic                   o_overflowed
);

    t_dp_cmd    cmd;
    t_dp_status status;

    isort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_list_end (i_list_end),
        .i_status   (status),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    isort_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_key_in     (i_key_in),
        .o_status     (status),
        .o_strobe     (o_strobe),
        .o_key_out    (o_key_out),
        .o_run_end    (o_run_end),
        .o_overflowed (o_overflowed)
    );

endmodule

`default_nettype wire
